// ----- src/tcm_pkg.sv -----
`timescale 1ns / 1ps

package tcm_pkg;

	localparam int RAW_W  = 8;
	localparam int FLD_W  = 16;
	localparam int OUT_W  = 32;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [ADDR_W-1:0] REG_X_RES = 3'd0;
	localparam logic [ADDR_W-1:0] REG_X_SIZ = 3'd1;
	localparam logic [ADDR_W-1:0] REG_X_OFL = 3'd2;
	localparam logic [ADDR_W-1:0] REG_Y_RES = 3'd3;
	localparam logic [ADDR_W-1:0] REG_Y_SIZ = 3'd4;
	localparam logic [ADDR_W-1:0] REG_Y_OFL = 3'd5;

	localparam logic [DATA_W-1:0] RES_RST  = 32'h00FF_00FF;
	localparam logic [DATA_W-1:0] SIZE_RST = 32'h0001_0001;

	// per-axis settings; the user must keep them static while items are in flight, the block does not enforce it
	typedef struct packed {
		logic [FLD_W-1:0] sen_res;
		logic [FLD_W-1:0] scr_res;
		logic [FLD_W-1:0] sen_size;
		logic [FLD_W-1:0] scr_size;
		logic [FLD_W-1:0] ofs;
		logic             mirror;
	} axis_cfg_t;

endpackage

// ----- src/tcm_div.sv -----
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per pipeline stage
module tcm_div #(
	parameter int DW = 24,
	parameter int VW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [DW-1:0] quotient,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [DW];
	logic [VW-1:0] rem_s  [DW];
	logic [DW-1:0] dq_s   [DW];
	logic [SW-1:0] side_s [DW];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic          vld_w;
		logic [VW-1:0] rem_w;
		logic [DW-1:0] dq_w;
		logic [SW-1:0] side_w;
		logic [VW:0]   trial;
		logic [VW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign vld_w  = in_valid;
			assign rem_w  = '0;
			assign dq_w   = dividend;
			assign side_w = side_in;
		end else begin : g_next
			assign vld_w  = vld_s[i-1];
			assign rem_w  = rem_s[i-1];
			assign dq_w   = dq_s[i-1];
			assign side_w = side_s[i-1];
		end

		// dividend bits shift out the top, quotient bits shift in the bottom
		assign trial = {rem_w, dq_w[DW-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_w;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
			dq_s[i]   <= {dq_w[DW-2:0], ge};
			side_s[i] <= side_w;
		end
	end

	assign out_valid = vld_s[DW-1];
	assign quotient  = dq_s[DW-1];
	assign side_out  = side_s[DW-1];

endmodule

// ----- src/tcm_axis.sv -----
`timescale 1ns / 1ps

module tcm_axis
	import tcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [RAW_W-1:0]        raw,
	input  axis_cfg_t               cfg,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] value
);

	localparam int P1_W   = RAW_W + FLD_W;      // raw * scr_res
	localparam int OM_W   = 2 * FLD_W;          // |ofs| * scr_res
	localparam int T2_W   = P1_W + 2;           // mirrored value, signed
	localparam int PR_W   = T2_W + FLD_W;       // t2 * sen_size, signed
	localparam int MG_W   = PR_W - 1;
	localparam int SUM_W  = PR_W + 1;

	logic ofs_neg;
	logic [FLD_W-1:0] ofs_abs;

	assign ofs_neg = cfg.ofs[FLD_W-1];
	assign ofs_abs = ofs_neg ? (~cfg.ofs + 1'b1) : cfg.ofs;

	// s1: both products
	logic            v_s1;
	logic [P1_W-1:0] p1_s1;
	logic [OM_W-1:0] om_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1 <= P1_W'(raw * cfg.scr_res);
		om_s1 <= OM_W'(ofs_abs * cfg.scr_res);
	end

	// offset term magnitude / scr_size, raw product rides along
	logic            vo;
	logic [OM_W-1:0] offq_o;
	logic [P1_W-1:0] p1_o;

	tcm_div #(.DW(OM_W), .VW(FLD_W), .SW(P1_W)) u_div_ofs (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.dividend (om_s1),
		.divisor  (cfg.scr_size),
		.side_in  (p1_s1),
		.out_valid(vo),
		.quotient (offq_o),
		.side_out (p1_o)
	);

	// raw * scr_res / sen_res
	logic            va;
	logic [P1_W-1:0] t1_a;
	logic [OM_W-1:0] offq_a;

	tcm_div #(.DW(P1_W), .VW(FLD_W), .SW(OM_W)) u_div_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vo),
		.dividend (p1_o),
		.divisor  (cfg.sen_res),
		.side_in  (offq_o),
		.out_valid(va),
		.quotient (t1_a),
		.side_out (offq_a)
	);

	// s2: mirror, s3: scale by sensor size, s4: magnitude for the divider
	logic                   v_s2, v_s3, v_s4;
	logic signed [T2_W-1:0] t2_s2;
	logic signed [PR_W-1:0] pr_s3;
	logic [MG_W-1:0]        mg_s4;
	logic                   neg_s4;
	logic [OM_W-1:0]        offq_s2, offq_s3, offq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= va;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cfg.mirror) begin
			t2_s2 <= $signed(T2_W'(cfg.scr_res) - T2_W'(t1_a));
		end else begin
			t2_s2 <= $signed(T2_W'(t1_a));
		end
		offq_s2 <= offq_a;
		pr_s3   <= t2_s2 * $signed({1'b0, cfg.sen_size});
		offq_s3 <= offq_s2;
		neg_s4  <= pr_s3[PR_W-1];
		mg_s4   <= pr_s3[PR_W-1] ? MG_W'(-pr_s3) : MG_W'(pr_s3);
		offq_s4 <= offq_s3;
	end

	logic              vb;
	logic [MG_W-1:0]   qb;
	logic [OM_W:0]     side_b;

	tcm_div #(.DW(MG_W), .VW(FLD_W), .SW(OM_W + 1)) u_div_siz (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.dividend (mg_s4),
		.divisor  (cfg.scr_size),
		.side_in  ({neg_s4, offq_s4}),
		.out_valid(vb),
		.quotient (qb),
		.side_out (side_b)
	);

	// s5: restore signs, s6: add and saturate
	logic                    v_s5, v_s6;
	logic signed [PR_W-1:0]  qs_s5;
	logic signed [OM_W:0]    os_s5;
	logic signed [OUT_W-1:0] value_s6;
	logic signed [SUM_W-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s5 <= vb;
			v_s6 <= v_s5;
		end
	end

	assign sum = SUM_W'(qs_s5) + SUM_W'(os_s5);

	always_ff @(posedge clk) begin
		qs_s5 <= side_b[OM_W] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
		os_s5 <= ofs_neg ? -$signed({1'b0, side_b[OM_W-1:0]})
		                 : $signed({1'b0, side_b[OM_W-1:0]});
		if (sum[SUM_W-1:OUT_W-1] == '0 || sum[SUM_W-1:OUT_W-1] == '1) begin
			value_s6 <= sum[OUT_W-1:0];
		end else if (sum[SUM_W-1]) begin
			value_s6 <= {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			value_s6 <= {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	assign out_valid = v_s6;
	assign value     = value_s6;

endmodule

// ----- src/touch_coordinate_mapper_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one coordinate pair per cycle; busy stays low.
// Latency is set by the bit-per-stage dividers (32 + 24 + 41 stages) plus six stages.
// Reset: arst_n clears all pipeline valids and loads the register reset values.
// The receiver cannot stall; done is a one-cycle strobe.
module touch_coordinate_mapper_unit
	import tcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [RAW_W-1:0]        raw_x,
	input  logic [RAW_W-1:0]        raw_y,
	input  logic                    cfg_we,
	input  logic [ADDR_W-1:0]       cfg_addr,
	input  logic [DATA_W-1:0]       cfg_wdata,
	output logic                    done,
	output logic signed [OUT_W-1:0] screen_x,
	output logic signed [OUT_W-1:0] screen_y,
	output logic                    divide_fault
);

	logic [DATA_W-1:0] x_res_q, x_siz_q, y_res_q, y_siz_q;
	logic [FLD_W:0]    x_ofl_q, y_ofl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_res_q <= RES_RST;
			x_siz_q <= SIZE_RST;
			x_ofl_q <= '0;
			y_res_q <= RES_RST;
			y_siz_q <= SIZE_RST;
			y_ofl_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_X_RES: x_res_q <= cfg_wdata;
				REG_X_SIZ: x_siz_q <= cfg_wdata;
				REG_X_OFL: x_ofl_q <= cfg_wdata[FLD_W:0];
				REG_Y_RES: y_res_q <= cfg_wdata;
				REG_Y_SIZ: y_siz_q <= cfg_wdata;
				REG_Y_OFL: y_ofl_q <= cfg_wdata[FLD_W:0];
				default: ;
			endcase
		end
	end

	axis_cfg_t cfg_x, cfg_y;

	assign cfg_x = '{sen_res: x_res_q[FLD_W-1:0], scr_res: x_res_q[DATA_W-1:FLD_W],
	                 sen_size: x_siz_q[FLD_W-1:0], scr_size: x_siz_q[DATA_W-1:FLD_W],
	                 ofs: x_ofl_q[FLD_W-1:0], mirror: x_ofl_q[FLD_W]};
	assign cfg_y = '{sen_res: y_res_q[FLD_W-1:0], scr_res: y_res_q[DATA_W-1:FLD_W],
	                 sen_size: y_siz_q[FLD_W-1:0], scr_size: y_siz_q[DATA_W-1:FLD_W],
	                 ofs: y_ofl_q[FLD_W-1:0], mirror: y_ofl_q[FLD_W]};

	logic                    accept;
	logic                    vx, vy;
	logic signed [OUT_W-1:0] ax, ay;
	logic                    fault;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	tcm_axis u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.raw      (raw_x),
		.cfg      (cfg_x),
		.out_valid(vx),
		.value    (ax)
	);

	tcm_axis u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.raw      (raw_y),
		.cfg      (cfg_y),
		.out_valid(vy),
		.value    (ay)
	);

	// the user must keep settings static while items are in flight (not enforced here), so fault comes straight from them
	assign fault = (cfg_x.sen_res == '0) || (cfg_x.scr_size == '0) ||
	               (cfg_y.sen_res == '0) || (cfg_y.scr_size == '0);

	assign done         = vx & vy;
	assign divide_fault = fault;
	assign screen_x     = fault ? '0 : ax;
	assign screen_y     = fault ? '0 : ay;

`ifndef ASSERT_OFF
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vx == vy)
		else $error("x and y pipelines out of step");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_fault |-> screen_x == '0 && screen_y == '0)
		else $error("fault transaction carries nonzero coordinates");
`endif

endmodule

// ----- dv/tcm_checker.sv -----
`timescale 1ns / 1ps

module tcm_checker
	import tcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [RAW_W-1:0]        raw_x,
	input  logic [RAW_W-1:0]        raw_y,
	input  logic                    cfg_we,
	input  logic [ADDR_W-1:0]       cfg_addr,
	input  logic [DATA_W-1:0]       cfg_wdata,
	input  logic                    done,
	input  logic signed [OUT_W-1:0] screen_x,
	input  logic signed [OUT_W-1:0] screen_y,
	input  logic                    divide_fault,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic                    fault;
	} coord_t;

	logic [DATA_W-1:0] regs [6];
	coord_t            expected_coords [$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// returns 0 on a zero divisor
	function automatic bit scale_axis(logic [RAW_W-1:0] v, logic [DATA_W-1:0] res,
		logic [DATA_W-1:0] siz, logic [DATA_W-1:0] ofl, output longint r);
		longint sen_res, scr_res, sen_size, scr_size, ofs, t;
		sen_res  = res[15:0];
		scr_res  = res[31:16];
		sen_size = siz[15:0];
		scr_size = siz[31:16];
		ofs      = longint'($signed(ofl[15:0]));
		r = 0;
		if (sen_res == 0 || scr_size == 0)
			return 0;
		t = (longint'(v) * scr_res) / sen_res;
		if (ofl[16])
			t = scr_res - t;
		t = (t * sen_size) / scr_size;
		r = t + (ofs * scr_res) / scr_size;
		return 1;
	endfunction

	function automatic coord_t map_touch(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
		coord_t c;
		longint rx, ry;
		bit okx, oky;
		okx = scale_axis(x, regs[REG_X_RES], regs[REG_X_SIZ], regs[REG_X_OFL], rx);
		oky = scale_axis(y, regs[REG_Y_RES], regs[REG_Y_SIZ], regs[REG_Y_OFL], ry);
		if (okx && oky) begin
			c.sx = OUT_W'(sat32(rx));
			c.sy = OUT_W'(sat32(ry));
			c.fault = 1'b0;
		end else begin
			c = '0;
			c.fault = 1'b1;
		end
		return c;
	endfunction

	assign pending = expected_coords.size();

	always @(posedge clk or negedge arst_n) begin
		coord_t e;
		if (!arst_n) begin
			regs[REG_X_RES] <= RES_RST;
			regs[REG_X_SIZ] <= SIZE_RST;
			regs[REG_X_OFL] <= '0;
			regs[REG_Y_RES] <= RES_RST;
			regs[REG_Y_SIZ] <= SIZE_RST;
			regs[REG_Y_OFL] <= '0;
			expected_coords.delete();
			fail_count <= 0;
		end else begin
			if (done) begin
				if (expected_coords.size() == 0) begin
					$error("unexpected transaction x=%0d y=%0d", screen_x, screen_y);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_coords.pop_front();
					if (screen_x !== e.sx || screen_y !== e.sy
						|| divide_fault !== e.fault)
						fail_count <= fail_count + 1;
					if (screen_x !== e.sx)
						$error("screen_x expected %0d actual %0d", e.sx, screen_x);
					if (screen_y !== e.sy)
						$error("screen_y expected %0d actual %0d", e.sy, screen_y);
					if (divide_fault !== e.fault)
						$error("divide_fault expected %0b actual %0b", e.fault,
							divide_fault);
				end
			end
			if (start && !busy)
				expected_coords.push_back(map_touch(raw_x, raw_y));
			if (cfg_we && cfg_addr <= REG_Y_OFL)
				regs[cfg_addr] <= (cfg_addr == REG_X_OFL || cfg_addr == REG_Y_OFL)
					? (cfg_wdata & 32'h1FFFF) : cfg_wdata;
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import tcm_pkg::*;

	localparam int LATENCY = 103;
	localparam int CYCLE_LIMIT = 400000;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    start = 0;
	logic                    busy;
	logic [RAW_W-1:0]        raw_x = '0;
	logic [RAW_W-1:0]        raw_y = '0;
	logic                    cfg_we = 0;
	logic [ADDR_W-1:0]       cfg_addr = '0;
	logic [DATA_W-1:0]       cfg_wdata = '0;
	logic                    done;
	logic signed [OUT_W-1:0] screen_x;
	logic signed [OUT_W-1:0] screen_y;
	logic                    divide_fault;
	int                      fail_count;
	int                      pending;
	int                      cycles = 0;
	int                      idle_pct = 0;

	always #4 clk = ~clk;

	touch_coordinate_mapper_unit i_dut (.*);

	tcm_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("touch_coordinate_mapper_unit test failed");
			$finish;
		end
	end

	task automatic send_touch(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5)
			@(posedge clk);
	endtask

	// leaves cfg_we high so writes can follow back to back
	task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
	endtask

	task automatic set_axes(input logic [DATA_W-1:0] xr, xs, xo,
		input logic [DATA_W-1:0] yr, ys, yo);
		write_reg(REG_X_RES, xr);
		write_reg(REG_X_SIZ, xs);
		write_reg(REG_X_OFL, xo);
		write_reg(REG_Y_RES, yr);
		write_reg(REG_Y_SIZ, ys);
		write_reg(REG_Y_OFL, yo);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly sane resolutions, some zero divisors and extremes
	function automatic logic [DATA_W-1:0] rand_pair();
		case ($urandom_range(9))
			0: return $urandom;
			1: return {16'($urandom_range(65535)), 16'd0};
			2: return 32'hFFFF_FFFF;
			default: return {16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))};
		endcase
	endfunction

	initial begin
		int phase;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then extremes
		send_touch(8'h00, 8'hFF);
		send_touch(8'hFF, 8'h00);
		send_touch(8'hAA, 8'h55);
		drain();
		set_axes(32'hFFFF_0001, 32'h0001_FFFF, 32'h0_7FFF,
			32'hFFFF_0001, 32'hFFFF_0001, 32'h1_8000);
		send_touch(8'hFF, 8'hFF);
		send_touch(8'h00, 8'h00);
		send_touch(8'h80, 8'h7F);
		drain();
		set_axes(32'h0400_00FF, 32'h0064_0032, 32'h1_FFFF,
			32'h0300_00FF, 32'h0001_FFFF, 32'h0_8000);
		send_touch(8'hFF, 8'h01);
		send_touch(8'h00, 8'hFE);
		drain();
		// zero divisors on each axis
		set_axes(32'h0100_0000, 32'h0001_0001, 32'h0, RES_RST, SIZE_RST, 32'h0);
		send_touch(8'h12, 8'h34);
		drain();
		set_axes(RES_RST, 32'h0000_0001, 32'h0, RES_RST, SIZE_RST, 32'h0);
		send_touch(8'h12, 8'h34);
		drain();
		set_axes(RES_RST, SIZE_RST, 32'h0, 32'h0100_0000, SIZE_RST, 32'h0);
		send_touch(8'h12, 8'h34);
		drain();
		set_axes(RES_RST, SIZE_RST, 32'h0, RES_RST, 32'hFFFF_0000, 32'h1_0000);
		send_touch(8'h12, 8'h34);
		drain();
		write_reg(3'd7, 32'hFFFF_FFFF);
		set_axes(32'hFFFF_FFFF, 32'h0001_FFFF, 32'h1_FFFF,
			32'hFFFF_FFFF, 32'h0001_FFFF, 32'h0_7FFF);
		send_touch(8'hFF, 8'h00);
		drain();

		for (phase = 0; phase < 30; phase++) begin
			idle_pct = (phase < 10) ? 14 : (phase < 20) ? 85 : 0;
			set_axes(rand_pair(), rand_pair(), $urandom_range(131071),
				rand_pair(), rand_pair(), $urandom_range(131071));
			repeat (30)
				send_touch($urandom_range(255), $urandom_range(255));
			drain();
		end

		if (fail_count == 0)
			$display("touch_coordinate_mapper_unit test passed");
		else
			$display("touch_coordinate_mapper_unit test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/tcm_pkg.sv
src/tcm_div.sv
src/tcm_axis.sv
src/touch_coordinate_mapper_unit.sv
dv/tcm_checker.sv
dv/testbench.sv
